[hw/rtl/bopl_pkg.sv]
// ----------------------------------------------------------------------------
// bopl_pkg
// Shared constants, types and helpers of the best-offset prefetch learner.
// ----------------------------------------------------------------------------
package bopl_pkg;

  localparam int ADDR_W       = 48;
  localparam int BLOCK_BITS   = 6;
  localparam int LINE_W       = ADDR_W - BLOCK_BITS;
  localparam int RR_ENTRIES   = 256;
  localparam int RR_IDX_W     = $clog2(RR_ENTRIES);
  localparam int LINE_TAG_W   = 12;
  localparam int NUM_OFFSETS  = 52;
  localparam int TI_W         = (NUM_OFFSETS > 1) ? $clog2(NUM_OFFSETS) : 1;
  localparam int OFF_W        = 10;
  localparam int DIFF_W       = (LINE_TAG_W > OFF_W) ? LINE_TAG_W : OFF_W;
  localparam int SCORE_W      = 8;
  localparam int ROUND_W      = 8;
  localparam int FILTER_DEPTH = 16;
  localparam int FI_W         = (FILTER_DEPTH > 1) ? $clog2(FILTER_DEPTH) : 1;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_W        = 8;

  localparam logic [SCORE_W-1:0] SCORE_SAT = '1;

  localparam logic [CFG_W-1:0] SCORE_LIM_RST = 8'd31;
  localparam logic [CFG_W-1:0] ROUND_LIM_RST = 8'd100;
  localparam logic [CFG_W-1:0] LOW_SCORE_RST = 8'd10;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SCORE_LIM = 2'd0,
    CFG_ROUND_LIM = 2'd1,
    CFG_LOW_SCORE = 2'd2
  } cfg_idx_t;

  // 2-3-5 smooth offsets
  localparam logic [OFF_W-1:0] OFFSET_LIST [64] = '{
    10'd1,   10'd2,   10'd3,   10'd4,   10'd5,   10'd6,   10'd8,   10'd9,
    10'd10,  10'd12,  10'd15,  10'd16,  10'd18,  10'd20,  10'd24,  10'd25,
    10'd27,  10'd30,  10'd32,  10'd36,  10'd40,  10'd45,  10'd48,  10'd50,
    10'd54,  10'd60,  10'd64,  10'd72,  10'd75,  10'd80,  10'd81,  10'd90,
    10'd96,  10'd100, 10'd108, 10'd120, 10'd125, 10'd128, 10'd135, 10'd144,
    10'd150, 10'd160, 10'd162, 10'd180, 10'd192, 10'd200, 10'd216, 10'd225,
    10'd240, 10'd243, 10'd250, 10'd256, 10'd270, 10'd288, 10'd300, 10'd320,
    10'd324, 10'd360, 10'd375, 10'd384, 10'd400, 10'd405, 10'd432, 10'd450
  };

  localparam logic [OFF_W-1:0] CHOSEN_RST = OFFSET_LIST[NUM_OFFSETS-1];
  localparam logic [TI_W-1:0]  TI_LAST    = TI_W'(NUM_OFFSETS - 1);

  typedef struct packed {
    logic              vld;
    logic              has_pc;
    logic [TI_W-1:0]   ti;
    logic [LINE_W-1:0] line;
  } bopl_s0_t;

  typedef struct packed {
    logic                  vld;
    logic                  has_pc;
    logic [TI_W-1:0]       ti;
    logic [OFF_W-1:0]      off;
    logic [LINE_W-1:0]     line;
    logic                  ge;
    logic                  dz;
    logic                  collide;
    logic [LINE_TAG_W-1:0] d;
  } bopl_s1_t;

  typedef struct packed {
    logic              vld;
    logic              has_pc;
    logic              en;
    logic [LINE_W-1:0] cand;
  } bopl_s2_t;

  function automatic logic [RR_IDX_W-1:0] rr_index(input logic [LINE_TAG_W-1:0] v);
    logic [LINE_TAG_W+RR_IDX_W-1:0] ext;
    logic [LINE_TAG_W+RR_IDX_W-1:0] h;
    ext = (LINE_TAG_W + RR_IDX_W)'(v);
    h   = ext ^ (ext >> RR_IDX_W);
    return h[RR_IDX_W-1:0];
  endfunction

endpackage

[hw/rtl/bopl_ram.sv]
// ----------------------------------------------------------------------------
// bopl_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bopl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // read returns the old contents on a same-address write
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[hw/rtl/bopl_recent.sv]
// ----------------------------------------------------------------------------
// bopl_recent
// Recent-requests table: writes the line tag, looks up tag minus offset.
// ----------------------------------------------------------------------------
module bopl_recent import bopl_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     adv,
  input  bopl_s0_t s0,
  output bopl_s1_t s1,
  output logic     hit
);

  logic [LINE_TAG_W-1:0] tag;
  logic [OFF_W-1:0]      off;
  logic [DIFF_W-1:0]     diff;
  logic [RR_IDX_W-1:0]   wi;
  logic [RR_IDX_W-1:0]   ri;
  logic                  go;
  logic [LINE_TAG_W-1:0] rd_tag;
  logic                  rvld_r [RR_ENTRIES];
  logic                  rv_r;
  bopl_s1_t              s1_nxt;
  bopl_s1_t              s1_r;

  always_comb begin
    tag  = s0.line[LINE_TAG_W-1:0];
    off  = OFFSET_LIST[6'(s0.ti)];
    diff = DIFF_W'(tag) - DIFF_W'(off);
    wi   = rr_index(tag);
    ri   = rr_index(diff[LINE_TAG_W-1:0]);
    go   = adv && s0.vld && s0.has_pc;

    s1_nxt.vld     = s0.vld;
    s1_nxt.has_pc  = s0.has_pc;
    s1_nxt.ti      = s0.ti;
    s1_nxt.off     = off;
    s1_nxt.line    = s0.line;
    s1_nxt.ge      = DIFF_W'(tag) >= DIFF_W'(off);
    s1_nxt.d       = diff[LINE_TAG_W-1:0];
    s1_nxt.dz      = (diff[LINE_TAG_W-1:0] == '0);
    s1_nxt.collide = (wi == ri);
  end

  bopl_ram #(
    .WIDTH(LINE_TAG_W),
    .DEPTH(RR_ENTRIES)
  ) u_tags (
    .clk    (clk),
    .wr_en  (go),
    .wr_addr(wi),
    .wr_data(tag),
    .rd_en  (go),
    .rd_addr(ri),
    .rd_data(rd_tag)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < RR_ENTRIES; i++) begin
        rvld_r[i] <= 1'b0;
      end
    end else if (go) begin
      rvld_r[wi] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      rv_r <= rvld_r[ri];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r.vld <= 1'b0;
    end else if (adv) begin
      s1_r <= s1_nxt;
    end
  end

  // a read of the slot this request writes returns the old tag: ignored unless the difference is zero
  assign hit = s1_r.ge && (s1_r.dz || (!s1_r.collide && rv_r && (rd_tag == s1_r.d)));
  assign s1  = s1_r;

endmodule

[hw/rtl/bopl_learner.sv]
// ----------------------------------------------------------------------------
// bopl_learner
// Offset scoring, round and phase control, throttle and prefetch candidate.
// ----------------------------------------------------------------------------
module bopl_learner import bopl_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             adv,
  input  bopl_s1_t         s1,
  input  logic             hit,
  input  logic [CFG_W-1:0] score_lim,
  input  logic [CFG_W-1:0] round_lim,
  input  logic [CFG_W-1:0] low_score,
  output bopl_s2_t         s2
);

  logic [SCORE_W-1:0] score_r [NUM_OFFSETS];
  logic [ROUND_W-1:0] round_r;
  logic [SCORE_W-1:0] pbs_r;
  logic [OFF_W-1:0]   pbo_r;
  logic [OFF_W-1:0]   chosen_r;
  logic               en_r;

  logic               train;
  logic [SCORE_W-1:0] new_score;
  logic               better;
  logic [SCORE_W-1:0] pbs1;
  logic [OFF_W-1:0]   pbo1;
  logic               last;
  logic [ROUND_W-1:0] rc1;
  logic               close;
  logic               mid;
  logic               en_nxt;
  logic [OFF_W-1:0]   chosen_nxt;
  bopl_s2_t           s2_nxt;
  bopl_s2_t           s2_r;

  always_comb begin
    train     = adv && s1.vld && s1.has_pc;
    new_score = score_r[0];
    if (hit && (score_r[0] != SCORE_SAT)) begin
      new_score = score_r[0] + 1'b1;
    end
    better = hit && (new_score > pbs_r);
    pbs1   = better ? new_score : pbs_r;
    pbo1   = better ? s1.off : pbo_r;
    last   = (s1.ti == TI_LAST);
    rc1    = round_r + 1'b1;
    close  = last && ((pbs1 >= score_lim) || (rc1 == round_lim));
    mid    = last && !close && (rc1 >= (round_lim >> 1)) && (chosen_r != pbo1) &&
             (pbs1 <= low_score);

    en_nxt     = en_r;
    chosen_nxt = chosen_r;
    if (s1.has_pc) begin
      if (close) begin
        en_nxt     = (pbs1 > low_score);
        chosen_nxt = pbo1;
      end else if (mid) begin
        en_nxt = 1'b0;
      end
    end

    s2_nxt.vld    = s1.vld;
    s2_nxt.has_pc = s1.has_pc;
    s2_nxt.en     = en_nxt;
    s2_nxt.cand   = s1.line + LINE_W'(chosen_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_OFFSETS; i++) begin
        score_r[i] <= '0;
      end
      round_r  <= '0;
      pbs_r    <= '0;
      pbo_r    <= '0;
      chosen_r <= CHOSEN_RST;
      en_r     <= 1'b0;
    end else if (train) begin
      en_r     <= en_nxt;
      chosen_r <= chosen_nxt;
      if (close) begin
        for (int i = 0; i < NUM_OFFSETS; i++) begin
          score_r[i] <= '0;
        end
        round_r <= '0;
        pbs_r   <= '0;
        pbo_r   <= '0;
      end else begin
        // scores rotate so the offset under test sits at the head
        for (int i = 0; i < NUM_OFFSETS - 1; i++) begin
          score_r[i] <= score_r[i+1];
        end
        score_r[NUM_OFFSETS-1] <= new_score;
        pbs_r <= pbs1;
        pbo_r <= pbo1;
        if (last) begin
          round_r <= rc1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_r.vld <= 1'b0;
    end else if (adv) begin
      s2_r <= s2_nxt;
    end
  end

  assign s2 = s2_r;

endmodule

[hw/rtl/bopl_filter.sv]
// ----------------------------------------------------------------------------
// bopl_filter
// Recent-prefetch FIFO filter and result register.
// ----------------------------------------------------------------------------
module bopl_filter import bopl_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              adv,
  input  bopl_s2_t          s2,
  output logic              out_valid,
  output logic              out_prefetch_valid,
  output logic [ADDR_W-1:0] out_prefetch_address,
  output logic              out_throttled
);

  logic [LINE_W-1:0] fa_r [FILTER_DEPTH];
  logic              fv_r [FILTER_DEPTH];
  logic [FI_W-1:0]   fnext_r;
  logic              match;
  logic              issue;
  logic              out_valid_r;
  logic              pf_valid_r;
  logic [ADDR_W-1:0] pf_addr_r;
  logic              throttled_r;

  always_comb begin
    match = 1'b0;
    for (int i = 0; i < FILTER_DEPTH; i++) begin
      if (fv_r[i] && (fa_r[i] == s2.cand)) begin
        match = 1'b1;
      end
    end
    issue = s2.vld && s2.has_pc && s2.en && !match;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < FILTER_DEPTH; i++) begin
        fv_r[i] <= 1'b0;
      end
      fnext_r <= '0;
    end else if (adv && issue) begin
      fv_r[fnext_r] <= 1'b1;
      fnext_r       <= (fnext_r == FI_W'(FILTER_DEPTH - 1)) ? '0 : fnext_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && issue) begin
      fa_r[fnext_r] <= s2.cand;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= s2.vld;
      pf_valid_r  <= issue;
      pf_addr_r   <= issue ? {s2.cand, BLOCK_BITS'(0)} : '0;
      throttled_r <= !s2.en;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_prefetch_valid   = pf_valid_r;
  assign out_prefetch_address = pf_addr_r;
  assign out_throttled        = throttled_r;

endmodule

[hw/rtl/best_offset_prefetch_learner_unit.sv]
// ----------------------------------------------------------------------------
// best_offset_prefetch_learner_unit
// Best-offset prefetch learner: trains on accesses, issues filtered prefetches.
// ----------------------------------------------------------------------------
// Takes one access request per clock while the pipeline is not halted and
// returns one result per request, in order. The rate is set by the recent-
// requests table, a RAM with one write and one registered read port that each
// request uses once; scoring and phase control take one stage after it and the
// prefetch filter with the result register one more. The whole pipeline halts
// while out_stall holds a result, and in_stall follows. Requests without a PC
// only pass through. cfg_ready is always high; registers are meant to be
// written while the unit is idle.
module best_offset_prefetch_learner_unit import bopl_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [ADDR_W-1:0]    in_byte_address,
  input  logic                 in_has_pc,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 out_prefetch_valid,
  output logic [ADDR_W-1:0]    out_prefetch_address,
  output logic                 out_throttled,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  logic             adv;
  logic [TI_W-1:0]  ti_r;
  bopl_s0_t         s0_r;
  bopl_s1_t         s1;
  bopl_s2_t         s2;
  logic             hit;
  logic [CFG_W-1:0] score_lim_r;
  logic [CFG_W-1:0] round_lim_r;
  logic [CFG_W-1:0] low_score_r;

  assign adv       = !(out_valid && out_stall);
  assign in_stall  = !adv;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      score_lim_r <= SCORE_LIM_RST;
      round_lim_r <= ROUND_LIM_RST;
      low_score_r <= LOW_SCORE_RST;
    end else if (cfg_valid) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_SCORE_LIM: score_lim_r <= cfg_data;
        CFG_ROUND_LIM: round_lim_r <= cfg_data;
        CFG_LOW_SCORE: low_score_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // offset under test advances once per request with a pc
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_r.vld <= 1'b0;
      ti_r     <= '0;
    end else if (adv) begin
      s0_r.vld    <= in_valid;
      s0_r.has_pc <= in_has_pc;
      s0_r.ti     <= ti_r;
      s0_r.line   <= in_byte_address[ADDR_W-1:BLOCK_BITS];
      if (in_valid && in_has_pc) begin
        ti_r <= (ti_r == TI_LAST) ? '0 : ti_r + 1'b1;
      end
    end
  end

  bopl_recent u_recent (
    .clk  (clk),
    .rst_n(rst_n),
    .adv  (adv),
    .s0   (s0_r),
    .s1   (s1),
    .hit  (hit)
  );

  bopl_learner u_learner (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .s1       (s1),
    .hit      (hit),
    .score_lim(score_lim_r),
    .round_lim(round_lim_r),
    .low_score(low_score_r),
    .s2       (s2)
  );

  bopl_filter u_filter (
    .clk                 (clk),
    .rst_n               (rst_n),
    .adv                 (adv),
    .s2                  (s2),
    .out_valid           (out_valid),
    .out_prefetch_valid  (out_prefetch_valid),
    .out_prefetch_address(out_prefetch_address),
    .out_throttled       (out_throttled)
  );

endmodule
